/* rtl/hts_pkg.sv */
// Shared types, character codes and tag-name tables for the HTML tag stripper.
// Used by every module of the block and by the channel interfaces.
package hts_pkg;

  localparam int CHAR_W   = 8;
  localparam int PAT_NUM  = 20;
  localparam int POS_W    = 3;
  localparam int CLOSE_W  = 4;

  localparam logic [POS_W-1:0]   POS_MAX      = 3'd7;
  localparam logic [PAT_NUM-1:0] ALL_ALIVE    = '1;
  localparam logic [CLOSE_W-1:0] SCRIPT_CLOSE_LEN = 4'd9;
  localparam logic [CLOSE_W-1:0] STYLE_CLOSE_LEN  = 4'd8;

  // Pattern slots with a special meaning; all others are newline tags.
  localparam int PAT_SCRIPT = 0;
  localparam int PAT_STYLE  = 1;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;

  typedef enum logic [5:0] {
    MODE_TEXT     = 6'b000001,
    MODE_TAG      = 6'b000010,
    MODE_SCR_OPEN = 6'b000100,
    MODE_SCR_BODY = 6'b001000,
    MODE_STY_OPEN = 6'b010000,
    MODE_STY_BODY = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [PAT_NUM-1:0] alive_next;
    logic               nl_hit;
    logic               script_hit;
    logic               style_hit;
  } match_t;

  typedef struct packed {
    logic              present;
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              end_of_text;
  } result_t;

  function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pat_len(input logic [4:0] idx);
    logic [POS_W-1:0] n;
    case (idx) inside
      5'd0:                   n = 3'd6;
      5'd1:                   n = 3'd5;
      5'd4:                   n = 3'd1;
      5'd3, 5'd6, 5'd12, 5'd13, 5'd14, 5'd15, 5'd17, 5'd19: n = 3'd3;
      5'd7:                   n = 3'd4;
      default:                n = 3'd2;
    endcase
    return n;
  endfunction

  // Tag-name prefixes, left-justified: element 0 is the first character.
  function automatic logic [CHAR_W-1:0] pat_char(input logic [4:0] idx,
                                                 input logic [POS_W-1:0] pos);
    logic [0:5][CHAR_W-1:0] t;
    case (idx)
      5'd0:  t = "script";
      5'd1:  t = {"style", 8'h00};
      5'd2:  t = {"br", 32'h0};
      5'd3:  t = {"/br", 24'h0};
      5'd4:  t = {"p", 40'h0};
      5'd5:  t = {"/p", 32'h0};
      5'd6:  t = {"div", 24'h0};
      5'd7:  t = {"/div", 16'h0};
      5'd8:  t = {"h1", 32'h0};
      5'd9:  t = {"h2", 32'h0};
      5'd10: t = {"h3", 32'h0};
      5'd11: t = {"h4", 32'h0};
      5'd12: t = {"/h1", 24'h0};
      5'd13: t = {"/h2", 24'h0};
      5'd14: t = {"/h3", 24'h0};
      5'd15: t = {"/h4", 24'h0};
      5'd16: t = {"li", 32'h0};
      5'd17: t = {"/li", 24'h0};
      5'd18: t = {"tr", 32'h0};
      5'd19: t = {"/tr", 24'h0};
      default: t = '0;
    endcase
    return (pos <= 3'd5) ? t[pos] : CH_NUL;
  endfunction

  function automatic logic [CHAR_W-1:0] close_char(input logic is_style,
                                                   input logic [CLOSE_W-1:0] k);
    logic [0:8][CHAR_W-1:0] t;
    t = is_style ? {"</style>", 8'h00} : "</script>";
    return (k <= 4'd8) ? t[k] : CH_NUL;
  endfunction

endpackage

/* rtl/hts_in_if.sv */
// Input channel of the HTML tag stripper: one HTML byte per request.
// Depends on hts_pkg for the character width.
interface hts_in_if import hts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, in_byte, in_last, input ready);
  modport sink   (input valid, in_byte, in_last, output ready);
endinterface

/* rtl/hts_out_if.sv */
// Output channel of the HTML tag stripper: one plain-text result per request.
// Depends on hts_pkg for the character width.
interface hts_out_if import hts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic              end_of_text;

  modport source (output valid, out_char, char_valid, end_of_text, input ready);
  modport sink   (input valid, out_char, char_valid, end_of_text, output ready);
endinterface

/* rtl/hts_tag_match.sv */
// Tag-name matcher: compares one lowercased name byte against all prefixes.
// Depends on hts_pkg for the prefix tables and the match_t result.
module hts_tag_match import hts_pkg::*; (
  input  logic [CHAR_W-1:0]  lc,
  input  logic [POS_W-1:0]   pos,
  input  logic [PAT_NUM-1:0] alive,
  output match_t             match
);

  logic [PAT_NUM-1:0] kill;
  logic [PAT_NUM-1:0] done;

  always_comb begin
    for (int i = 0; i < PAT_NUM; i++) begin
      logic [POS_W-1:0] len;
      logic             active;
      logic             eq;
      len     = pat_len(5'(i));
      active  = alive[i] && (pos < len);
      eq      = (pat_char(5'(i), pos) == lc);
      kill[i] = active && !eq;
      done[i] = active && eq && (({1'b0, pos} + 4'd1) == {1'b0, len});
    end
  end

  always_comb begin
    match.alive_next = alive & ~kill;
    match.script_hit = done[PAT_SCRIPT];
    match.style_hit  = done[PAT_STYLE];
    match.nl_hit     = |done[PAT_NUM-1:PAT_STYLE+1];
  end

endmodule

/* rtl/hts_parser.sv */
// Parser state and per-byte next-state logic of the HTML tag stripper.
// Depends on hts_pkg and hts_tag_match.
module hts_parser import hts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [CHAR_W-1:0] cur_byte,
  input  logic              cur_last,
  output result_t           res
);

  mode_t               mode, mode_next;
  logic [POS_W-1:0]    tag_pos, tag_pos_next;
  logic [PAT_NUM-1:0]  alive, alive_next;
  logic                nl_seen, nl_seen_next;
  logic [CLOSE_W-1:0]  close_cnt, close_cnt_next;
  logic                last_space, last_space_next;
  logic                last_nl, last_nl_next;
  logic                text_ended, text_ended_next;

  logic [CHAR_W-1:0]   lc;
  match_t              match;

  assign lc = lower_byte(cur_byte);

  hts_tag_match u_match (
    .lc    (lc),
    .pos   (tag_pos),
    .alive (alive),
    .match (match)
  );

  always_comb begin
    logic              emit;
    logic [CHAR_W-1:0] ch;
    logic              is_style;
    logic [CLOSE_W-1:0] clen;
    logic [CLOSE_W-1:0] k1;

    mode_next       = mode;
    tag_pos_next    = tag_pos;
    alive_next      = alive;
    nl_seen_next    = nl_seen;
    close_cnt_next  = close_cnt;
    last_space_next = last_space;
    last_nl_next    = last_nl;
    text_ended_next = text_ended;
    emit            = 1'b0;
    ch              = CH_NUL;
    is_style        = (mode == MODE_STY_BODY);
    clen            = is_style ? STYLE_CLOSE_LEN : SCRIPT_CLOSE_LEN;
    k1              = close_cnt + 4'd1;

    if (!text_ended) begin
      if (cur_byte == CH_NUL) begin
        text_ended_next = 1'b1;
        if (mode == MODE_TAG && nl_seen && !last_nl) begin
          emit = 1'b1;
          ch   = CH_LF;
          last_space_next = 1'b1;
          last_nl_next    = 1'b1;
        end
      end else begin
        unique case (mode) inside
          MODE_TEXT: begin
            if (cur_byte == CH_LT) begin
              mode_next    = MODE_TAG;
              tag_pos_next = '0;
              alive_next   = ALL_ALIVE;
              nl_seen_next = 1'b0;
            end else if (cur_byte != CH_CR) begin
              if (cur_byte == CH_TAB || cur_byte == CH_LF || cur_byte == CH_SPACE) begin
                if (!last_space) begin
                  emit = 1'b1;
                  ch   = CH_SPACE;
                  last_space_next = 1'b1;
                  last_nl_next    = 1'b0;
                end
              end else begin
                emit = 1'b1;
                ch   = cur_byte;
                last_space_next = 1'b0;
                last_nl_next    = 1'b0;
              end
            end
          end
          MODE_TAG: begin
            if (cur_byte == CH_GT) begin
              mode_next = MODE_TEXT;
              if (nl_seen && !last_nl) begin
                emit = 1'b1;
                ch   = CH_LF;
                last_space_next = 1'b1;
                last_nl_next    = 1'b1;
              end
            end else if (match.script_hit) begin
              mode_next      = MODE_SCR_OPEN;
              close_cnt_next = '0;
            end else if (match.style_hit) begin
              mode_next      = MODE_STY_OPEN;
              close_cnt_next = '0;
            end else begin
              alive_next   = match.alive_next;
              nl_seen_next = nl_seen | match.nl_hit;
              if (tag_pos != POS_MAX) tag_pos_next = tag_pos + 3'd1;
            end
          end
          MODE_SCR_OPEN: begin
            if (cur_byte == CH_GT) mode_next = MODE_SCR_BODY;
          end
          MODE_STY_OPEN: begin
            if (cur_byte == CH_GT) mode_next = MODE_STY_BODY;
          end
          MODE_SCR_BODY, MODE_STY_BODY: begin
            // Look for the closing tag; a '<' restarts the match.
            if (close_cnt < clen && close_char(is_style, close_cnt) == lc) begin
              if (k1 == clen) begin
                mode_next      = MODE_TEXT;
                close_cnt_next = '0;
              end else begin
                close_cnt_next = k1;
              end
            end else begin
              close_cnt_next = (lc == CH_LT) ? 4'd1 : 4'd0;
            end
          end
          default: mode_next = MODE_TEXT;
        endcase
      end

      // A document that ends inside a newline tag still gets its newline.
      if (cur_last && !emit && mode_next == MODE_TAG && nl_seen_next && !last_nl_next) begin
        emit = 1'b1;
        ch   = CH_LF;
      end
    end

    res.present     = emit || cur_last;
    res.out_char    = emit ? ch : CH_NUL;
    res.char_valid  = emit;
    res.end_of_text = cur_last;

    if (cur_last) begin
      mode_next       = MODE_TEXT;
      tag_pos_next    = '0;
      alive_next      = ALL_ALIVE;
      nl_seen_next    = 1'b0;
      close_cnt_next  = '0;
      last_space_next = 1'b1;
      last_nl_next    = 1'b1;
      text_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_TEXT;
      tag_pos    <= '0;
      alive      <= ALL_ALIVE;
      nl_seen    <= 1'b0;
      close_cnt  <= '0;
      last_space <= 1'b1;
      last_nl    <= 1'b1;
      text_ended <= 1'b0;
    end else if (step) begin
      mode       <= mode_next;
      tag_pos    <= tag_pos_next;
      alive      <= alive_next;
      nl_seen    <= nl_seen_next;
      close_cnt  <= close_cnt_next;
      last_space <= last_space_next;
      last_nl    <= last_nl_next;
      text_ended <= text_ended_next;
    end
  end

endmodule

/* rtl/html_tag_stripper_core.sv */
// HTML tag stripper, top level.
// Channels: html (sink) takes one HTML byte per request with in_last marking the
// final byte of a document; text (source) gives one result per request with the
// plain-text character, char_valid and end_of_text.
// A byte yields a result only when it emits a character or carries in_last;
// the other bytes are consumed without a result.
// A byte accepted from html waits in the input register; its result goes on
// through the result register to text. Throughput: one byte per cycle unless text
// stalls, set by the single input and result registers around the parser logic.
// Stall: while a result waits on text, one more byte is taken into the input
// register; html.ready then drops until the result is taken.
// Reset (rst, synchronous) empties both registers and puts the parser in text
// mode as if a newline had just been emitted. A result with end_of_text also
// returns the parser to that state for the next document.
// Depends on hts_pkg, hts_in_if, hts_out_if and hts_parser.
module html_tag_stripper_core import hts_pkg::*; (
  input logic      clk,
  input logic      rst,
  hts_in_if.sink   html,
  hts_out_if.source text
);

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_byte;
  logic              s1_last;
  logic              advance;
  logic              accept;
  result_t           res;

  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic              end_of_text;

  assign advance    = s1_valid && (!out_valid || text.ready);
  assign html.ready = !s1_valid || advance;
  assign accept     = html.valid && html.ready;

  hts_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .cur_byte (s1_byte),
    .cur_last (s1_last),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= html.in_byte;
      s1_last <= html.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.present) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.present) begin
      out_char    <= res.out_char;
      char_valid  <= res.char_valid;
      end_of_text <= res.end_of_text;
    end
  end

  assign text.valid       = out_valid;
  assign text.out_char    = out_char;
  assign text.char_valid  = char_valid;
  assign text.end_of_text = end_of_text;

endmodule

/* rtl/hts_checker.sv */
// Port-level checks for the HTML tag stripper, bound to the top level.
// Depends on hts_pkg for the character codes.
module hts_checker import hts_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              html_valid,
  input logic              html_ready,
  input logic              text_valid,
  input logic              text_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              char_valid,
  input logic              end_of_text
);

  // A stalled result keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid && $stable(out_char) &&
      $stable(char_valid) && $stable(end_of_text))
    else $error("result changed while stalled");

  // A result without a character only exists to close a document.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    text_valid && !char_valid |-> end_of_text && out_char == CH_NUL)
    else $error("empty result without end_of_text");

  // A zero byte ends the text and is never passed through.
  a_no_nul_char: assert property (@(posedge clk) disable iff (rst)
    text_valid && char_valid |-> out_char != CH_NUL)
    else $error("zero character emitted");

  // A request is only held off while a result is stalled on the output.
  a_in_backpressure: assert property (@(posedge clk) disable iff (rst)
    html_valid && !html_ready |-> text_valid && !text_ready)
    else $error("request refused without a stalled result");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !text_valid)
    else $error("result pending after reset");

endmodule

bind html_tag_stripper_core hts_checker u_hts_checker (
  .clk         (clk),
  .rst         (rst),
  .html_valid  (html.valid),
  .html_ready  (html.ready),
  .text_valid  (text.valid),
  .text_ready  (text.ready),
  .out_char    (text.out_char),
  .char_valid  (text.char_valid),
  .end_of_text (text.end_of_text)
);

/* dv/tb_html_tag_stripper_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for html_tag_stripper_core: a short table of directed bytes, some with
// results given in the table, and then random HTML documents checked against a behavioral stripper.
// Depends on hts_pkg, hts_in_if, hts_out_if and the RTL of the block.
module tb_html_tag_stripper_core;
  import hts_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1250;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              eot;
  } text_item_t;

  typedef struct {
    logic [CHAR_W-1:0] b;
    logic              is_last;
    logic              typed;
    logic [CHAR_W-1:0] ch;
    logic              valid;
    logic              eot;
  } intro_row_t;

  logic clk = 1'b0;
  logic rst;

  hts_in_if  html_ch ();
  hts_out_if text_ch ();

  html_tag_stripper_core dut (
    .clk  (clk),
    .rst  (rst),
    .html (html_ch),
    .text (text_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tag-name prefixes in slot order; slots 0 and 1 open script and style bodies.
  string tag_prefix[PAT_NUM] = '{"script", "style", "br", "/br", "p", "/p", "div", "/div",
                                 "h1", "h2", "h3", "h4", "/h1", "/h2", "/h3", "/h4",
                                 "li", "/li", "tr", "/tr"};
  string nl_tag_pool[23] = '{"br", "/br", "p", "/p", "div", "/div", "h1", "h2", "h3", "h4",
                             "/h1", "/h4", "li", "/li", "tr", "/tr", "pre", "hr", "h5", "/h",
                             "brx", "divider", "d"};

  // Parser state of the behavioral stripper.
  mode_t              st_mode;
  logic [POS_W-1:0]   st_pos;
  logic [PAT_NUM-1:0] st_alive;
  logic               st_nl_tag;
  logic [CLOSE_W-1:0] st_close;
  logic               st_space;
  logic               st_nl_out;
  logic               st_ended;

  text_item_t text_expect_q[$];
  logic [CHAR_W-1:0] doc_q[$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 81;

  function automatic void clear_parser();
    st_mode   = MODE_TEXT;
    st_pos    = '0;
    st_alive  = ALL_ALIVE;
    st_nl_tag = 1'b0;
    st_close  = '0;
    st_space  = 1'b1;
    st_nl_out = 1'b1;
    st_ended  = 1'b0;
  endfunction

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic logic tag_close_newline();
    logic emit;
    emit = st_nl_tag && !st_nl_out;
    if (emit) begin
      st_space  = 1'b1;
      st_nl_out = 1'b1;
    end
    return emit;
  endfunction

  function automatic void match_tag_char(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] lc;
    int n;
    lc = fold_case(c);
    for (int i = 0; i < PAT_NUM; i++) begin
      n = tag_prefix[i].len();
      if (!st_alive[i] || st_pos >= n) continue;
      if (tag_prefix[i][st_pos] != lc) begin
        st_alive[i] = 1'b0;
      end else if (st_pos + 1 == n) begin
        // A full script or style name switches mode at once and ends the name scan.
        if (i == PAT_SCRIPT) begin
          st_mode  = MODE_SCR_OPEN;
          st_close = '0;
          return;
        end
        if (i == PAT_STYLE) begin
          st_mode  = MODE_STY_OPEN;
          st_close = '0;
          return;
        end
        st_nl_tag = 1'b1;
      end
    end
    if (st_pos != POS_MAX) st_pos++;
  endfunction

  function automatic void scan_body(input logic [CHAR_W-1:0] c, input string closer);
    logic [CHAR_W-1:0] lc;
    lc = fold_case(c);
    if (st_close < closer.len() && closer[st_close] == lc) begin
      st_close++;
      if (st_close == closer.len()) begin
        st_mode  = MODE_TEXT;
        st_close = '0;
      end
    end else begin
      st_close = (lc == CH_LT) ? 4'd1 : 4'd0;
    end
  endfunction

  // Advances the stripper by one byte; returns 1 when the byte yields a result.
  function automatic logic strip_byte(input logic [CHAR_W-1:0] c, input logic is_last,
                                      output text_item_t res);
    logic emit;
    logic [CHAR_W-1:0] ch;
    emit = 1'b0;
    ch   = CH_NUL;
    if (!st_ended) begin
      if (c == CH_NUL) begin
        st_ended = 1'b1;
        if (st_mode == MODE_TAG) begin
          if (tag_close_newline()) begin
            emit = 1'b1;
            ch   = CH_LF;
          end
        end
      end else begin
        case (st_mode)
          MODE_TEXT: begin
            if (c == CH_LT) begin
              st_mode   = MODE_TAG;
              st_pos    = '0;
              st_alive  = ALL_ALIVE;
              st_nl_tag = 1'b0;
            end else if (c == CH_TAB || c == CH_LF || c == CH_SPACE) begin
              if (!st_space) begin
                emit      = 1'b1;
                ch        = CH_SPACE;
                st_space  = 1'b1;
                st_nl_out = 1'b0;
              end
            end else if (c != CH_CR) begin
              emit      = 1'b1;
              ch        = c;
              st_space  = 1'b0;
              st_nl_out = 1'b0;
            end
          end
          MODE_TAG: begin
            if (c == CH_GT) begin
              st_mode = MODE_TEXT;
              if (tag_close_newline()) begin
                emit = 1'b1;
                ch   = CH_LF;
              end
            end else begin
              match_tag_char(c);
            end
          end
          MODE_SCR_OPEN: begin
            if (c == CH_GT) st_mode = MODE_SCR_BODY;
          end
          MODE_STY_OPEN: begin
            if (c == CH_GT) st_mode = MODE_STY_BODY;
          end
          MODE_SCR_BODY: begin
            scan_body(c, "</script>");
          end
          MODE_STY_BODY: begin
            scan_body(c, "</style>");
          end
          default: begin
            st_mode = MODE_TEXT;
          end
        endcase
      end
      // A document that stops inside a newline tag still gets its newline.
      if (is_last && !emit && st_mode == MODE_TAG) begin
        if (tag_close_newline()) begin
          emit = 1'b1;
          ch   = CH_LF;
        end
      end
    end
    res.ch    = emit ? ch : CH_NUL;
    res.valid = emit;
    res.eot   = is_last;
    if (is_last) clear_parser();
    return emit || is_last;
  endfunction

  // Sends one byte; the expectation is queued at the edge where the request is taken.
  task automatic push_byte(input logic [CHAR_W-1:0] b, input logic is_last,
                           input logic typed, input text_item_t typed_res);
    text_item_t res;
    logic has_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      html_ch.valid <= 1'b0;
      @(posedge clk);
    end
    html_ch.valid   <= 1'b1;
    html_ch.in_byte <= b;
    html_ch.in_last <= is_last;
    do @(posedge clk); while (!html_ch.ready);
    has_res = strip_byte(b, is_last, res);
    if (typed) text_expect_q.push_back(typed_res);
    else if (has_res) text_expect_q.push_back(res);
  endtask

  function automatic void add_text(input string s, input logic mix);
    logic [CHAR_W-1:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix && c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
      doc_q.push_back(c);
    end
  endfunction

  function automatic logic [CHAR_W-1:0] word_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(33, 126));
    return (c == CH_LT) ? "x" : c;
  endfunction

  function automatic void add_hidden_block(input string name);
    string closer;
    closer = {"</", name, ">"};
    doc_q.push_back(CH_LT);
    add_text(name, 1'b1);
    if ($urandom_range(0, 3) == 0) add_text(" type=x", 1'b1);
    doc_q.push_back(CH_GT);
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 5))
        0: doc_q.push_back(CH_LT);
        1: add_text("</scr", 1'b1);
        2: add_text("</sty", 1'b1);
        3: add_text("<</", 1'b0);
        default: doc_q.push_back(word_char());
      endcase
    end
    // Now and then the body is never closed, which hides the rest of the document.
    if ($urandom_range(0, 9) != 0) add_text(closer, 1'b1);
  endfunction

  function automatic void add_fragment();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      repeat ($urandom_range(1, 6)) doc_q.push_back(word_char());
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 3))
          0: doc_q.push_back(CH_SPACE);
          1: doc_q.push_back(CH_TAB);
          2: doc_q.push_back(CH_LF);
          default: doc_q.push_back(CH_CR);
        endcase
      end
    end else if (pick < 60) begin
      doc_q.push_back(CH_LT);
      add_text(nl_tag_pool[$urandom_range(0, $size(nl_tag_pool) - 1)], 1'b1);
      if ($urandom_range(0, 3) == 0) add_text(" id=q", 1'b1);
      doc_q.push_back(CH_GT);
    end else if (pick < 70) begin
      doc_q.push_back(CH_LT);
      if ($urandom_range(0, 4) == 0) add_text("!--a--", 1'b0);
      else repeat ($urandom_range(1, 9)) doc_q.push_back(CHAR_W'($urandom_range("a", "z")));
      doc_q.push_back(CH_GT);
    end else if (pick < 78) begin
      add_hidden_block("script");
    end else if (pick < 85) begin
      add_hidden_block("style");
    end else if (pick < 93) begin
      repeat ($urandom_range(1, 3)) doc_q.push_back(CHAR_W'($urandom_range(128, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) doc_q.push_back(CHAR_W'($urandom_range(1, 255)));
    end
  endfunction

  always @(posedge clk) begin : text_sink
    text_item_t want;
    if (rst) begin
      text_ch.ready <= 1'b0;
    end else begin
      text_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (text_ch.valid && text_ch.ready) begin
        if (text_expect_q.size() == 0) begin
          $error("unexpected result: out_char %02h char_valid %0b end_of_text %0b",
                 text_ch.out_char, text_ch.char_valid, text_ch.end_of_text);
          fail_cnt++;
        end else begin
          want = text_expect_q.pop_front();
          if (text_ch.out_char !== want.ch) begin
            $error("out_char: expected %02h, got %02h", want.ch, text_ch.out_char);
            fail_cnt++;
          end
          if (text_ch.char_valid !== want.valid) begin
            $error("char_valid: expected %0b, got %0b", want.valid, text_ch.char_valid);
            fail_cnt++;
          end
          if (text_ch.end_of_text !== want.eot) begin
            $error("end_of_text: expected %0b, got %0b", want.eot, text_ch.end_of_text);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  intro_row_t intro_rows[23] = '{
    '{"A",      1'b0, 1'b1, "A",    1'b1, 1'b0},
    '{8'hFF,    1'b0, 1'b1, 8'hFF,  1'b1, 1'b0},
    '{CH_SPACE, 1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_TAB,   1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_LT,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{"B",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{"R",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_GT,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{"x",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_LT,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{"p",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_NUL,   1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{8'h80,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{8'h7F,    1'b1, 1'b1, CH_NUL, 1'b0, 1'b1},
    '{"y",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_LT,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{"L",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{"I",      1'b1, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_SPACE, 1'b1, 1'b1, CH_NUL, 1'b0, 1'b1},
    '{"q",      1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_CR,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_LF,    1'b0, 1'b0, CH_NUL, 1'b0, 1'b0},
    '{CH_NUL,   1'b1, 1'b1, CH_NUL, 1'b0, 1'b1}
  };

  initial begin : stimulus
    int counted;
    int end_kind;
    text_item_t typed_res;
    rst             <= 1'b1;
    html_ch.valid   <= 1'b0;
    html_ch.in_byte <= '0;
    html_ch.in_last <= 1'b0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (intro_rows[i]) begin
      typed_res = '{intro_rows[i].ch, intro_rows[i].valid, intro_rows[i].eot};
      push_byte(intro_rows[i].b, intro_rows[i].is_last, intro_rows[i].typed, typed_res);
    end

    // Let the block drain completely before the random documents start.
    html_ch.valid <= 1'b0;
    while (text_expect_q.size() != 0) @(posedge clk);

    counted = 0;
    while (counted < RANDOM_BYTES) begin
      if (counted < RANDOM_BYTES / 3) begin
        send_idle_pct = 38;
        recv_idle_pct = 81;
      end else if (counted < 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      doc_q.delete();
      repeat ($urandom_range(1, 12)) add_fragment();
      end_kind = $urandom_range(0, 9);
      if (end_kind == 0) begin
        // Stop inside a tag with no closing bracket.
        doc_q.push_back(CH_LT);
        add_text(nl_tag_pool[$urandom_range(0, $size(nl_tag_pool) - 1)], 1'b1);
      end
      counted += doc_q.size();
      if (end_kind == 1 || end_kind == 2) begin
        // Zero byte, then a few bytes that are ignored until the end of the document.
        doc_q.push_back(CH_NUL);
        counted++;
        repeat ($urandom_range(0, 3)) doc_q.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      foreach (doc_q[i]) push_byte(doc_q[i], i == doc_q.size() - 1, 1'b0, '0);
    end

    html_ch.valid <= 1'b0;
    recv_idle_pct = 0;
    while (text_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
